[src/hkseq_pkg.sv]
package hkseq_pkg;

	localparam int CODE_W      = 9;
	localparam int VK_W        = 8;
	localparam int CNT_W       = 3;
	localparam int LEN_LSB     = 56;
	localparam int HOTKEY_W    = 59;
	localparam int CFG_IDX_W   = 3;
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 24;
	localparam int HIDX_W      = 2;

	localparam int HELD_DEPTH_DEF  = 16;
	localparam int STACK_DEPTH_DEF = 7;
	localparam int NUM_HOTKEYS_DEF = 4;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_REPEAT     = 3'd1,
		ST_UNHELD     = 3'd2,
		ST_HELD_FULL  = 3'd3,
		ST_STACK_FULL = 3'd4
	} status_t;

	// request to every held-set cell
	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic              set;
		logic              clr;
	} held_op_t;

	// request to every stack cell
	typedef struct packed {
		logic [VK_W-1:0]  vk;
		logic [CNT_W-1:0] count;
		logic             push;
	} stack_op_t;

endpackage

[src/hkseq_held_cell.sv]
module hkseq_held_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  hkseq_pkg::held_op_t op,
	input  logic             free_in,
	output logic             free_out,
	output logic             match
);
	import hkseq_pkg::*;

	logic [CODE_W-1:0] code_q;
	logic              valid_q;
	logic              claim;

	assign match    = valid_q && (code_q == op.code);
	// first free slot along the row takes the new code
	assign claim    = op.set && !free_in && !valid_q;
	assign free_out = free_in || !valid_q;

	always_ff @(posedge clk) begin
		if (claim) begin
			code_q <= op.code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (claim) begin
			valid_q <= 1'b1;
		end else if (op.clr && match) begin
			valid_q <= 1'b0;
		end
	end

endmodule

[src/hkseq_stack_cell.sv]
module hkseq_stack_cell #(
	parameter int IDX         = 0,
	parameter int NUM_HOTKEYS = hkseq_pkg::NUM_HOTKEYS_DEF
) (
	input  logic                                  clk,
	input  hkseq_pkg::stack_op_t                  op,
	input  logic [NUM_HOTKEYS-1:0][hkseq_pkg::VK_W-1:0]  keys,
	input  logic [NUM_HOTKEYS-1:0][hkseq_pkg::CNT_W-1:0] lens,
	input  logic [NUM_HOTKEYS-1:0]                match_in,
	output logic [NUM_HOTKEYS-1:0]                match_out,
	output logic                                  top_eq
);
	import hkseq_pkg::*;

	logic [VK_W-1:0] byte_q;
	logic [VK_W-1:0] eff;
	logic            at_count;

	assign at_count = (op.count == CNT_W'(IDX));
	// view of this slot after the pending push
	assign eff      = at_count ? op.vk : byte_q;
	// this slot is the top of the current stack and holds the released key
	assign top_eq   = (op.count == CNT_W'(IDX + 1)) && (byte_q == op.vk);

	always_comb begin
		for (int h = 0; h < NUM_HOTKEYS; h++) begin
			match_out[h] = match_in[h] &&
				((CNT_W'(IDX) >= lens[h]) || (eff == keys[h]));
		end
	end

	always_ff @(posedge clk) begin
		if (op.push && at_count) begin
			byte_q <= op.vk;
		end
	end

endmodule

[src/hotkey_sequence_detector_top.sv]
// An input request is captured, then evaluated into the result registers on m_tdata.
// A new event waits until the last one is evaluated; evaluation waits while a result is unread.
// The held-set search and hotkey compare ripple along their rows of cells in the evaluate cycle.
// Reset (arst_n low, async): held set and stack empty, hotkey registers zero, no result pending.
// No clearing pass is needed after reset.
module hotkey_sequence_detector_top #(
	parameter int HELD_DEPTH  = hkseq_pkg::HELD_DEPTH_DEF,
	parameter int STACK_DEPTH = hkseq_pkg::STACK_DEPTH_DEF,
	parameter int NUM_HOTKEYS = hkseq_pkg::NUM_HOTKEYS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// [8:0] scan_code, [16:9] virtual_key, [23:17] zero
	input  logic [hkseq_pkg::IN_TDATA_W-1:0]    s_tdata,
	// [0] is_press
	input  logic                                s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [0] forward_key, [1] hotkey_hit, [3:2] hotkey_index, [12:4] out_scan_code,
	// [20:13] out_virtual_key, [23:21] status
	output logic [hkseq_pkg::OUT_TDATA_W-1:0]   m_tdata,
	// [0] out_is_press
	output logic                                m_tuser,
	input  logic                                cfg_we,
	input  logic [hkseq_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [hkseq_pkg::HOTKEY_W-1:0]      cfg_data
);
	import hkseq_pkg::*;

	logic [HOTKEY_W-1:0] hotkey_q [NUM_HOTKEYS];

	logic              busy_q;
	logic [CODE_W-1:0] sc_q;
	logic [VK_W-1:0]   vk_q;
	logic              press_q;
	logic [CNT_W-1:0]  cnt_q;

	logic              m_valid_q;
	logic              fwd_q;
	logic              hit_q;
	logic [HIDX_W-1:0] hidx_q;
	logic [CODE_W-1:0] osc_q;
	logic [VK_W-1:0]   ovk_q;
	logic              opress_q;
	status_t           status_q;

	logic commit;
	logic in_acc;

	held_op_t  held_op;
	stack_op_t stack_op;

	logic [HELD_DEPTH:0]   free_chain;
	logic [HELD_DEPTH-1:0] held_match;
	logic                  held_hit;
	logic                  held_full;
	logic                  stack_full;

	logic [STACK_DEPTH:0][NUM_HOTKEYS-1:0] seq_chain;
	logic [STACK_DEPTH-1:0]                top_eq;
	logic [NUM_HOTKEYS-1:0][VK_W-1:0]      keys [STACK_DEPTH];
	logic [NUM_HOTKEYS-1:0][CNT_W-1:0]     lens;

	logic              push_ok;
	logic              any_hit;
	logic [HIDX_W-1:0] hidx;
	logic              fwd;
	status_t           status;
	logic [CNT_W-1:0]  cnt_next;

	assign s_tready = !busy_q;
	assign in_acc   = s_tvalid && s_tready;
	assign commit   = busy_q && (!m_valid_q || m_tready);

	// configuration
	for (genvar h = 0; h < NUM_HOTKEYS; h++) begin : g_cfg
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				hotkey_q[h] <= '0;
			end else if (cfg_we && (cfg_index == CFG_IDX_W'(h))) begin
				hotkey_q[h] <= cfg_data;
			end
		end
		assign lens[h] = hotkey_q[h][LEN_LSB +: CNT_W];
	end

	// held set row
	assign free_chain[0] = 1'b0;
	assign held_hit      = |held_match;
	assign held_full     = !free_chain[HELD_DEPTH];
	assign stack_full    = (cnt_q >= CNT_W'(STACK_DEPTH));
	assign push_ok       = press_q && !held_hit && !held_full && !stack_full;

	always_comb begin
		held_op.code = sc_q;
		held_op.set  = commit && push_ok;
		held_op.clr  = commit && !press_q;
	end

	for (genvar i = 0; i < HELD_DEPTH; i++) begin : g_held
		hkseq_held_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.op       (held_op),
			.free_in  (free_chain[i]),
			.free_out (free_chain[i+1]),
			.match    (held_match[i])
		);
	end

	// stack row; match flags run along the cells
	always_comb begin
		stack_op.vk    = vk_q;
		stack_op.count = cnt_q;
		stack_op.push  = commit && push_ok;
	end

	assign seq_chain[0] = '1;

	for (genvar k = 0; k < STACK_DEPTH; k++) begin : g_stack
		for (genvar h = 0; h < NUM_HOTKEYS; h++) begin : g_key
			assign keys[k][h] = hotkey_q[h][VK_W*k +: VK_W];
		end
		hkseq_stack_cell #(
			.IDX         (k),
			.NUM_HOTKEYS (NUM_HOTKEYS)
		) u_cell (
			.clk       (clk),
			.op        (stack_op),
			.keys      (keys[k]),
			.lens      (lens),
			.match_in  (seq_chain[k]),
			.match_out (seq_chain[k+1]),
			.top_eq    (top_eq[k])
		);
	end

	// first matching hotkey wins
	always_comb begin
		any_hit = 1'b0;
		hidx    = '0;
		for (int h = NUM_HOTKEYS - 1; h >= 0; h--) begin
			if (seq_chain[STACK_DEPTH][h] &&
			    ({1'b0, lens[h]} == ({1'b0, cnt_q} + (CNT_W+1)'(1)))) begin
				any_hit = 1'b1;
				hidx    = HIDX_W'(h);
			end
		end
	end

	always_comb begin
		fwd      = 1'b1;
		status   = ST_OK;
		cnt_next = cnt_q;
		if (press_q) begin
			if (held_hit) begin
				fwd    = 1'b0;
				status = ST_REPEAT;
			end else if (held_full) begin
				status = ST_HELD_FULL;
			end else if (stack_full) begin
				status = ST_STACK_FULL;
			end else begin
				cnt_next = cnt_q + CNT_W'(1);
				fwd      = !any_hit;
			end
		end else begin
			if (!held_hit) begin
				status = ST_UNHELD;
			end
			if (cnt_q != '0) begin
				cnt_next = (|top_eq) ? (cnt_q - CNT_W'(1)) : '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			cnt_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				busy_q <= 1'b1;
			end else if (commit) begin
				busy_q <= 1'b0;
			end
			if (commit) begin
				cnt_q     <= cnt_next;
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			sc_q    <= s_tdata[CODE_W-1:0];
			vk_q    <= s_tdata[CODE_W +: VK_W];
			press_q <= s_tuser;
		end
		if (commit) begin
			fwd_q    <= fwd;
			hit_q    <= push_ok && any_hit;
			hidx_q   <= (push_ok && any_hit) ? hidx : '0;
			osc_q    <= sc_q;
			ovk_q    <= vk_q;
			opress_q <= press_q;
			status_q <= status;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {status_q, ovk_q, osc_q, hidx_q, hit_q, fwd_q};
	assign m_tuser  = opress_q;

	// assertions
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(STACK_DEPTH))
		else $error("stack count beyond depth");

	a_held_unique: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(held_match))
		else $error("scan code held in more than one slot");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !s_tready)
		else $error("request taken while one is being evaluated");

	a_hit_not_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && hit_q |-> !fwd_q && (status_q == ST_OK) && opress_q)
		else $error("hotkey hit forwarded or with bad status");

	a_cnt_commit: assert property (@(posedge clk) disable iff (!arst_n)
		!commit |=> $stable(cnt_q))
		else $error("stack count moved without an evaluate");

endmodule

[tb/sv/hotkey_event_checker.sv]
module hotkey_event_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	input  logic                              s_tready,
	// [8:0] scan_code, [16:9] virtual_key, [23:17] zero
	input  logic [hkseq_pkg::IN_TDATA_W-1:0]  s_tdata,
	// [0] is_press
	input  logic                              s_tuser,
	input  logic                              m_tvalid,
	input  logic                              m_tready,
	// [0] forward_key, [1] hotkey_hit, [3:2] hotkey_index, [12:4] out_scan_code,
	// [20:13] out_virtual_key, [23:21] status
	input  logic [hkseq_pkg::OUT_TDATA_W-1:0] m_tdata,
	// [0] out_is_press
	input  logic                              m_tuser,
	input  logic                              cfg_we,
	input  logic [hkseq_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [hkseq_pkg::HOTKEY_W-1:0]    cfg_data,
	output int                                errors,
	output int                                pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import hkseq_pkg::*;

	localparam int HELD_N    = HELD_DEPTH_DEF;
	localparam int STACK_N   = STACK_DEPTH_DEF;
	localparam int SLOTS     = NUM_HOTKEYS_DEF;
	localparam int MAX_SHOWN = 10;

	typedef struct {
		logic              fwd;
		logic              hit;
		logic [HIDX_W-1:0] idx;
		logic [CODE_W-1:0] sc;
		logic [VK_W-1:0]   vk;
		logic              press;
		status_t           st;
	} key_result_t;

	logic [HOTKEY_W-1:0] hotkey     [SLOTS];
	logic [CODE_W-1:0]   held_code  [HELD_N];
	logic                held_vld   [HELD_N];
	logic [VK_W-1:0]     vk_stack   [STACK_N];
	int                  depth;
	key_result_t         expected_q [$];

	// walks one key event through the held set and the press stack
	function automatic key_result_t judge_event(input logic [CODE_W-1:0] sc,
			input logic [VK_W-1:0] vk, input logic press);
		key_result_t r;
		int i, h, k, len, pos, slot;
		logic same;
		r.fwd   = 1'b1;
		r.hit   = 1'b0;
		r.idx   = '0;
		r.sc    = sc;
		r.vk    = vk;
		r.press = press;
		r.st    = ST_OK;
		pos  = -1;
		slot = -1;
		for (i = 0; i < HELD_N; i++)
			if (pos < 0 && held_vld[i] && held_code[i] == sc)
				pos = i;
		if (press) begin
			if (pos >= 0) begin
				r.fwd = 1'b0;
				r.st  = ST_REPEAT;
			end else begin
				for (i = 0; i < HELD_N; i++)
					if (slot < 0 && !held_vld[i])
						slot = i;
				if (slot < 0) begin
					r.st = ST_HELD_FULL;
				end else if (depth >= STACK_N) begin
					r.st = ST_STACK_FULL;
				end else begin
					held_code[slot] = sc;
					held_vld[slot]  = 1'b1;
					vk_stack[depth] = vk;
					depth++;
					for (h = 0; h < SLOTS; h++) begin
						len  = int'(hotkey[h][LEN_LSB +: CNT_W]);
						same = (len != 0) && (len == depth);
						for (k = 0; k < STACK_N; k++)
							if (same && k < len && hotkey[h][8*k +: 8] != vk_stack[k])
								same = 1'b0;
						if (same && !r.hit) begin
							r.hit = 1'b1;
							r.idx = h[HIDX_W-1:0];
							r.fwd = 1'b0;
						end
					end
				end
			end
		end else begin
			if (pos >= 0)
				held_vld[pos] = 1'b0;
			else
				r.st = ST_UNHELD;
			// pop on matching top, otherwise drop the whole stack
			if (depth > 0) begin
				if (vk_stack[depth-1] == vk)
					depth--;
				else
					depth = 0;
			end
		end
		return r;
	endfunction

	task automatic log_fault(input string msg);
		errors++;
		if (errors <= MAX_SHOWN)
			$display("%s", msg);
	endtask

	task automatic queue_expected(input key_result_t r);
		expected_q.insert(expected_q.size(), r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		key_result_t want;
		logic        bad;
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++)
				hotkey[i] = '0;
			for (int i = 0; i < HELD_N; i++) begin
				held_code[i] = '0;
				held_vld[i]  = 1'b0;
			end
			for (int i = 0; i < STACK_N; i++)
				vk_stack[i] = '0;
			depth = 0;
			expected_q.delete();
			errors = 0;
			pending <= 0;
		end else begin
			if (cfg_we && cfg_index < SLOTS)
				hotkey[cfg_index[HIDX_W-1:0]] = cfg_data;
			if (m_tvalid && m_tready) begin
				if (expected_q.size() == 0) begin
					log_fault($sformatf("unexpected result tdata=%06h tuser=%0d", m_tdata, m_tuser));
				end else begin
					want = expected_q.pop_front();
					bad  = (m_tdata[0] !== want.fwd) || (m_tdata[1] !== want.hit) ||
					       (m_tdata[3:2] !== want.idx) || (m_tdata[12:4] !== want.sc) ||
					       (m_tdata[20:13] !== want.vk) || (m_tuser !== want.press) ||
					       (m_tdata[23:21] !== want.st);
					if (bad)
						log_fault($sformatf({"mismatch exp fwd=%0d hit=%0d idx=%0d sc=%03h vk=%02h",
							" press=%0d st=%0d | got fwd=%0d hit=%0d idx=%0d sc=%03h vk=%02h",
							" press=%0d st=%0d"},
							want.fwd, want.hit, want.idx, want.sc, want.vk, want.press,
							want.st, m_tdata[0], m_tdata[1], m_tdata[3:2], m_tdata[12:4],
							m_tdata[20:13], m_tuser, m_tdata[23:21]));
				end
			end
			if (s_tvalid && s_tready)
				queue_expected(judge_event(s_tdata[CODE_W-1:0],
					s_tdata[CODE_W +: VK_W], s_tuser));
			pending <= expected_q.size();
		end
	end

endmodule

[tb/sv/tb_hotkey_sequence_detector_top.sv]
module tb_hotkey_sequence_detector_top;
	timeunit 1ns;
	timeprecision 1ps;

	import hkseq_pkg::*;

	localparam int HK_SLOTS    = NUM_HOTKEYS_DEF;
	localparam int PHASES      = 7;
	localparam int RAND_ITEMS  = 1950;
	localparam int HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES = 20;
	localparam int CYCLE_LIMIT = 400000;

	localparam logic            KEY_DOWN = 1'b1;
	localparam logic            KEY_UP   = 1'b0;
	// a release with it clears the stack unless it is on top; random traffic can push it too
	localparam logic [VK_W-1:0] FLUSH_VK = 8'hFF;

	typedef enum {
		CFG_DIRECTED,
		CFG_OVERLAP,
		CFG_CLEAR,
		CFG_ALL_ONES,
		CFG_SHORT,
		CFG_WILD
	} cfg_style_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tuser;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [HOTKEY_W-1:0]    cfg_data;

	int errors;
	int pending;
	int cycles = 0;
	int sent = 0;
	int tx_idle_pct = 0;
	int rx_stall_pct;
	logic hold_go;
	logic hold_on;

	logic [HOTKEY_W-1:0] hk_cfg     [HK_SLOTS];
	logic [CODE_W-1:0]   down_codes [$];

	cfg_style_t phase_cfg [PHASES] = '{CFG_OVERLAP, CFG_ALL_ONES, CFG_SHORT, CFG_OVERLAP,
	                                   CFG_CLEAR, CFG_WILD, CFG_SHORT};
	int         phase_tx  [PHASES] = '{0, 47, 0, 8, 47, 0, 8};
	int         phase_rx  [PHASES] = '{0, 0, 47, 8, 0, 47, 8};

	hotkey_sequence_detector_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	hotkey_event_checker u_chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(posedge clk)
		m_tready <= !hold_on && ($urandom_range(0, 99) >= rx_stall_pct);

	// long receiver hold-off so the block backs up into its input
	initial begin
		hold_on <= 1'b0;
		wait (hold_go);
		hold_on <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_on <= 1'b0;
	end

	task automatic note_down(input logic [CODE_W-1:0] sc);
		down_codes.insert(down_codes.size(), sc);
	endtask

	task automatic send_key(input logic [CODE_W-1:0] sc, input logic [VK_W-1:0] vk,
			input logic press);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(IN_TDATA_W-CODE_W-VK_W){1'b0}}, vk, sc};
		s_tuser  <= press;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sent++;
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic program_hotkeys(input cfg_style_t style);
		logic [63:0]         w;
		logic [HOTKEY_W-1:0] v;
		int                  h, k;
		for (h = 0; h < HK_SLOTS; h++) begin
			w = {$urandom, $urandom};
			v = w[HOTKEY_W-1:0];
			case (style)
				CFG_DIRECTED: begin
					// slot 3 duplicates slot 0 so the lower index must win
					if (h == 1)
						v = '1;
					else if (h == 2)
						v = '0;
					else
						v = {3'd2, 40'd0, 8'h20, 8'h10};
				end
				CFG_OVERLAP: begin
					if (h > 0 && $urandom_range(0, 1))
						v[LEN_LSB-1:0] = hk_cfg[h-1][LEN_LSB-1:0];
					v[LEN_LSB +: CNT_W] = CNT_W'($urandom_range(0, 7));
					for (k = 0; k < 7; k++)
						if (v[8*k +: 8] == FLUSH_VK)
							v[8*k +: 8] = 8'hFE;
				end
				CFG_CLEAR:    v = '0;
				CFG_ALL_ONES: v = '1;
				CFG_SHORT: begin
					for (k = 0; k < 7; k++)
						v[8*k +: 8] = VK_W'($urandom_range(0, 3));
					v[LEN_LSB +: CNT_W] = CNT_W'($urandom_range(1, 2));
				end
				default: ;
			endcase
			hk_cfg[h]  = v;
			cfg_we    <= 1'b1;
			cfg_index <= CFG_IDX_W'(h);
			cfg_data  <= v;
			@(posedge clk);
		end
		// index past the last slot must be ignored
		w = {$urandom, $urandom};
		cfg_we    <= 1'b1;
		cfg_index <= CFG_IDX_W'(HK_SLOTS + $urandom_range(0, (1 << CFG_IDX_W) - HK_SLOTS - 1));
		cfg_data  <= w[HOTKEY_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// presses the keys of a configured sequence (random keys if none is set) in order, then releases them;
	// a broken run may alter one key, may drop or add one, or releases out of order
	task automatic play_sequence(input bit broken);
		logic [VK_W-1:0]   keys [8];
		logic [CODE_W-1:0] base;
		int                h, k, j, len, n, flaw, start;
		for (k = 0; k < 8; k++)
			keys[k] = VK_W'($urandom_range(0, 254));
		start = $urandom_range(0, HK_SLOTS-1);
		len   = 0;
		for (k = 0; k < HK_SLOTS; k++) begin
			j = (start + k) % HK_SLOTS;
			if (len == 0 && hk_cfg[j][LEN_LSB +: CNT_W] != 0) begin
				h   = j;
				len = int'(hk_cfg[j][LEN_LSB +: CNT_W]);
			end
		end
		if (len == 0)
			len = $urandom_range(1, 7);
		else
			for (k = 0; k < len; k++)
				keys[k] = hk_cfg[h][8*k +: 8];
		n    = len;
		flaw = broken ? $urandom_range(0, 3) : 4;
		case (flaw)
			0: begin
				j = $urandom_range(0, len-1);
				keys[j][$urandom_range(0, 7)] = ~keys[j][$urandom_range(0, 7)];
			end
			1: n = (n > 1) ? n - 1 : 2;
			2: n = n + 1;
			default: ;
		endcase
		base = CODE_W'($urandom_range(32, (1 << CODE_W) - 9));
		send_key(base + CODE_W'(8), FLUSH_VK, KEY_UP);
		for (k = 0; k < n; k++) begin
			send_key(base + CODE_W'(k), keys[k], KEY_DOWN);
			if (k == 0 && $urandom_range(0, 3) == 0)
				send_key(base, keys[0], KEY_DOWN);
		end
		if (flaw == 3)
			for (k = 0; k < n; k++)
				send_key(base + CODE_W'(k), keys[k], KEY_UP);
		else
			for (k = n - 1; k >= 0; k--)
				send_key(base + CODE_W'(k), keys[k], KEY_UP);
	endtask

	task automatic noise_burst();
		logic [CODE_W-1:0] sc;
		logic [VK_W-1:0]   vk;
		logic              press;
		int                n, k;
		n = $urandom_range(1, 6);
		for (k = 0; k < n; k++) begin
			sc    = CODE_W'($urandom_range(0, 1) ? $urandom_range(0, 15) :
			                $urandom_range(0, 511));
			vk    = $urandom_range(0, 1) ?
			        hk_cfg[$urandom_range(0, HK_SLOTS-1)][8*$urandom_range(0, 6) +: 8] :
			        VK_W'($urandom_range(0, 255));
			press = 1'($urandom_range(0, 1));
			if (press)
				note_down(sc);
			send_key(sc, vk, press);
		end
	endtask

	task automatic release_all();
		logic [CODE_W-1:0] sc;
		while (down_codes.size() > 0) begin
			sc = down_codes.pop_front();
			send_key(sc, FLUSH_VK, KEY_UP);
		end
	endtask

	initial begin
		int p, r, goal, down_limit;
		arst_n       <= 1'b0;
		s_tvalid     <= 1'b0;
		s_tdata      <= '0;
		s_tuser      <= 1'b0;
		cfg_we       <= 1'b0;
		cfg_index    <= '0;
		cfg_data     <= '0;
		hold_go      <= 1'b0;
		rx_stall_pct <= 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		program_hotkeys(CFG_DIRECTED);
		send_key(9'h1FF, 8'h00, KEY_UP);    // release not held, empty stack
		send_key(9'h000, 8'h10, KEY_DOWN);
		send_key(9'h000, 8'h10, KEY_DOWN);  // repeat press
		send_key(9'h1FF, 8'h20, KEY_DOWN);  // completes slot 0 (and its duplicate)
		send_key(9'h1FF, 8'h20, KEY_UP);    // pop
		send_key(9'h000, 8'h33, KEY_UP);    // top differs: clear
		for (int k = 1; k <= 7; k++)
			send_key(CODE_W'(k), FLUSH_VK, KEY_DOWN);  // seventh press hits the all-ones slot
		send_key(9'd8, FLUSH_VK, KEY_DOWN); // stack full
		send_key(9'h100, 8'h00, KEY_UP);
		for (int k = 8; k <= 14; k++)
			send_key(CODE_W'(k), 8'h5A, KEY_DOWN);
		send_key(9'h101, 8'h00, KEY_UP);
		send_key(9'd15, 8'h00, KEY_DOWN);
		send_key(9'd16, 8'h01, KEY_DOWN);
		send_key(9'd17, 8'h02, KEY_DOWN);   // held set full
		for (int k = 1; k <= 17; k++)
			note_down(CODE_W'(k));
		release_all();

		down_limit = 12;
		for (p = 0; p < PHASES; p++) begin
			wait_idle();
			program_hotkeys(phase_cfg[p]);
			tx_idle_pct   = phase_tx[p];
			rx_stall_pct <= phase_rx[p];
			if (p == 0)
				hold_go <= 1'b1;
			goal = sent + RAND_ITEMS / PHASES;
			while (sent < goal) begin
				r = $urandom_range(0, 99);
				if (r < 55)
					play_sequence(1'b0);
				else if (r < 72)
					play_sequence(1'b1);
				else
					noise_burst();
				if (down_codes.size() > down_limit) begin
					release_all();
					down_limit = $urandom_range(4, 24);
				end
			end
		end

		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

[hotkey_sequence_detector_top.f]
src/hkseq_pkg.sv
src/hkseq_held_cell.sv
src/hkseq_stack_cell.sv
src/hotkey_sequence_detector_top.sv
tb/sv/hotkey_event_checker.sv
tb/sv/tb_hotkey_sequence_detector_top.sv
